// File: rtl/efu_pkg.sv
`timescale 1ns / 1ps
package efu_pkg;

  // field and register widths
  localparam int FLD_W     = 24;
  localparam int ANG_W     = 16;
  localparam int CFG_W     = 16;
  localparam int FLR_W     = 23;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 23;
  localparam int IN_W      = 8 * FLD_W + ANG_W;
  localparam int OUT_W     = 4 * FLD_W;
  localparam int PAIR_W    = 4 * FLD_W;

  // cordic
  localparam int CORD_STAGES = 16;
  localparam int CX_W        = 33;
  localparam int CZ_W        = 26;
  localparam int TRIG_W      = 18;
  localparam logic signed [CX_W-1:0] CORDIC_K = 33'sd652032874;
  localparam logic signed [CZ_W-1:0] ANG_QTR  = 26'sd4194304;
  localparam logic signed [CZ_W-1:0] ANG_HALF = 26'sd8388608;

  // datapath widths
  localparam int PROD_W = FLD_W + TRIG_W;
  localparam int ROT_W  = 30;
  localparam int SQ_W   = 62;
  localparam int RT_W   = 31;
  localparam int REM_W  = 35;
  localparam int W_W    = CFG_W + TRIG_W;
  localparam int T_W    = 30;

  // pipeline depths
  localparam int SQRT_STAGES = RT_W;
  localparam int CORDIC_LAT  = CORD_STAGES + 2;
  localparam int LANE_LAT    = 4 + SQRT_STAGES + 4 + SQRT_STAGES + 1;
  localparam int PIPE_LAT    = CORDIC_LAT + LANE_LAT;
  localparam int W_DLY       = 3 + SQRT_STAGES + 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ANGLE = 3'd0,
    CFG_AMP_FRAC  = 3'd1,
    CFG_PHASE_ERR = 3'd2,
    CFG_FLOOR_E   = 3'd3,
    CFG_FLOOR_H   = 3'd4
  } cfg_idx_e;

  // one square-root step state
  typedef struct packed {
    logic [SQ_W-1:0]  v;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
  } sq_t;

  // arctangent table, 2^24 per turn
  function automatic logic signed [CZ_W-1:0] atan_lut(input logic [3:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      4'd0:    r = 26'sd2097152;
      4'd1:    r = 26'sd1238021;
      4'd2:    r = 26'sd654136;
      4'd3:    r = 26'sd332050;
      4'd4:    r = 26'sd166669;
      4'd5:    r = 26'sd83416;
      4'd6:    r = 26'sd41718;
      4'd7:    r = 26'sd20860;
      4'd8:    r = 26'sd10430;
      4'd9:    r = 26'sd5215;
      4'd10:   r = 26'sd2608;
      4'd11:   r = 26'sd1304;
      4'd12:   r = 26'sd652;
      4'd13:   r = 26'sd326;
      4'd14:   r = 26'sd163;
      default: r = 26'sd81;
    endcase
    return r;
  endfunction

  // restoring square root, one result bit per call
  function automatic sq_t sq_step(input sq_t a);
    sq_t r;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    sh    = {a.rem[REM_W-3:0], a.v[SQ_W-1 -: 2]};
    trial = {{(REM_W-RT_W-2){1'b0}}, a.root, 2'b01};
    r.v   = {a.v[SQ_W-3:0], 2'b00};
    if (sh >= trial) begin
      r.rem  = sh - trial;
      r.root = {a.root[RT_W-2:0], 1'b1};
    end else begin
      r.rem  = sh;
      r.root = {a.root[RT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// File: rtl/efu_isqrt.sv
`timescale 1ns / 1ps
module efu_isqrt import efu_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [SQ_W-1:0] rad_i,
  output logic [RT_W-1:0] root_o
);

  sq_t st_q [SQRT_STAGES];
  sq_t seed;

  assign seed = '{v: rad_i, rem: '0, root: '0};

  // one bit of the root per stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sq_step(seed);
      for (int k = 1; k < SQRT_STAGES; k++) begin
        st_q[k] <= sq_step(st_q[k-1]);
      end
    end
  end

  assign root_o = st_q[SQRT_STAGES-1].root;

endmodule

// File: rtl/efu_cordic.sv
`timescale 1ns / 1ps
module efu_cordic import efu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ANG_W-1:0]         ang_i,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  logic signed [CX_W-1:0] x_q [CORD_STAGES+1];
  logic signed [CX_W-1:0] y_q [CORD_STAGES+1];
  logic signed [CZ_W-1:0] z_q [CORD_STAGES+1];
  logic                   neg_q [CORD_STAGES+1];

  logic signed [CZ_W-1:0] z_raw;
  logic signed [CX_W-1:0] x_rnd;
  logic signed [CX_W-1:0] y_rnd;
  logic signed [TRIG_W-1:0] c_d;
  logic signed [TRIG_W-1:0] s_d;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [TRIG_W-1:0] sin_q;

  // angle scaled to 2^24 per turn
  assign z_raw = {{(CZ_W-ANG_W-8){ang_i[ANG_W-1]}}, ang_i, 8'b0};

  // fold into the right half plane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_K;
      y_q[0] <= '0;
      if (z_raw > ANG_QTR) begin
        z_q[0]   <= z_raw - ANG_HALF;
        neg_q[0] <= 1'b1;
      end else if (z_raw < -ANG_QTR) begin
        z_q[0]   <= z_raw + ANG_HALF;
        neg_q[0] <= 1'b1;
      end else begin
        z_q[0]   <= z_raw;
        neg_q[0] <= 1'b0;
      end
    end
  end

  // rotation iterations
  for (genvar i = 0; i < CORD_STAGES; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][CZ_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_lut(4'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_lut(4'(i));
        end
      end
    end
  end

  // round to q1.15 and undo the fold
  assign x_rnd = x_q[CORD_STAGES] + CX_W'(16384);
  assign y_rnd = y_q[CORD_STAGES] + CX_W'(16384);
  assign c_d   = x_rnd[CX_W-1:15];
  assign s_d   = y_rnd[CX_W-1:15];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= neg_q[CORD_STAGES] ? -c_d : c_d;
      sin_q <= neg_q[CORD_STAGES] ? -s_d : s_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// File: rtl/efu_lane.sv
`timescale 1ns / 1ps
module efu_lane import efu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  logic [PAIR_W-1:0]        pair_i,   // x_re, x_im, y_re, y_im
  input  logic [CFG_W-1:0]         amp_frac_i,
  input  logic [CFG_W-1:0]         phase_err_i,
  input  logic [FLR_W-1:0]         floor_i,
  output logic [FLD_W-1:0]         unc_x_o,
  output logic [FLD_W-1:0]         unc_y_o
);

  logic signed [FLD_W-1:0] f_in [4];
  logic signed [FLD_W-1:0] f1_q [4];
  logic signed [FLD_W-1:0] f2_q [4];
  logic signed [PROD_W-1:0] pr_q [8];
  logic signed [PROD_W:0]   rsum [4];
  logic signed [PROD_W:0]   rrnd [4];
  logic signed [ROT_W-1:0]  rot_q [4];
  logic [2*ROT_W-1:0]       rsq_q [4];
  logic [2*FLD_W-1:0]       fsq_q [4];
  logic [SQ_W-1:0]          rad_q [4];
  logic [TRIG_W-1:0]        abs_c;
  logic [TRIG_W-1:0]        abs_s;
  logic [W_W-1:0]           wc_q [W_DLY];
  logic [W_W-1:0]           ws_q [W_DLY];
  logic [RT_W-1:0]          mag [4];
  logic [RT_W+W_W-1:0]      pa_q [4];
  logic [RT_W+CFG_W-1:0]    pp_q [2];
  logic [RT_W+W_W-1:0]      pa_rnd [4];
  logic [RT_W+CFG_W-1:0]    pp_rnd [2];
  logic [T_W-1:0]           t_q [7];
  logic [2*T_W-1:0]         tsq_q [7];
  logic [SQ_W-1:0]          usum_q [2];
  logic [RT_W-1:0]          uroot [2];
  logic [RT_W:0]            ur_rnd [2];
  logic [RT_W-4:0]          ur_sh [2];
  logic [FLD_W-1:0]         unc_q [2];

  for (genvar j = 0; j < 4; j++) begin : g_unpack
    assign f_in[j] = pair_i[j*FLD_W +: FLD_W];
  end

  assign abs_c = cos_i[TRIG_W-1] ? TRIG_W'(-cos_i) : TRIG_W'(cos_i);
  assign abs_s = sin_i[TRIG_W-1] ? TRIG_W'(-sin_i) : TRIG_W'(sin_i);

  // rotation products and amplitude weights
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q[0] <= f_in[0] * cos_i;
      pr_q[1] <= f_in[2] * sin_i;
      pr_q[2] <= f_in[1] * cos_i;
      pr_q[3] <= f_in[3] * sin_i;
      pr_q[4] <= f_in[0] * sin_i;
      pr_q[5] <= f_in[2] * cos_i;
      pr_q[6] <= f_in[1] * sin_i;
      pr_q[7] <= f_in[3] * cos_i;
      f1_q    <= f_in;
      wc_q[0] <= amp_frac_i * abs_c;
      ws_q[0] <= amp_frac_i * abs_s;
      for (int k = 1; k < W_DLY; k++) begin
        wc_q[k] <= wc_q[k-1];
        ws_q[k] <= ws_q[k-1];
      end
    end
  end

  // rotated parts rounded to q.4
  assign rsum[0] = (PROD_W+1)'(pr_q[0]) - (PROD_W+1)'(pr_q[1]);
  assign rsum[1] = (PROD_W+1)'(pr_q[2]) - (PROD_W+1)'(pr_q[3]);
  assign rsum[2] = (PROD_W+1)'(pr_q[4]) + (PROD_W+1)'(pr_q[5]);
  assign rsum[3] = (PROD_W+1)'(pr_q[6]) + (PROD_W+1)'(pr_q[7]);

  for (genvar j = 0; j < 4; j++) begin : g_rnd
    assign rrnd[j] = rsum[j] + (PROD_W+1)'(1024);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        rot_q[k] <= rrnd[k][11 +: ROT_W];
      end
      f2_q <= f1_q;
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        rsq_q[k] <= (2*ROT_W)'(rot_q[k] * rot_q[k]);
        fsq_q[k] <= (2*FLD_W)'(f2_q[k] * f2_q[k]);
      end
    end
  end

  // magnitude radicands: rotated x, rotated y, raw x, raw y
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q[0] <= SQ_W'(rsq_q[0]) + SQ_W'(rsq_q[1]);
      rad_q[1] <= SQ_W'(rsq_q[2]) + SQ_W'(rsq_q[3]);
      rad_q[2] <= (SQ_W'(fsq_q[0]) + SQ_W'(fsq_q[1])) << 8;
      rad_q[3] <= (SQ_W'(fsq_q[2]) + SQ_W'(fsq_q[3])) << 8;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_mag
    efu_isqrt u_mag (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rad_i  (rad_q[j]),
      .root_o (mag[j])
    );
  end

  // amplitude and phase products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q[0] <= mag[2] * wc_q[W_DLY-1];
      pa_q[1] <= mag[3] * ws_q[W_DLY-1];
      pa_q[2] <= mag[2] * ws_q[W_DLY-1];
      pa_q[3] <= mag[3] * wc_q[W_DLY-1];
      pp_q[0] <= mag[1] * phase_err_i;
      pp_q[1] <= mag[0] * phase_err_i;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_parnd
    assign pa_rnd[j] = pa_q[j] + (RT_W+W_W)'(64'd1 << 30);
  end
  for (genvar j = 0; j < 2; j++) begin : g_pprnd
    assign pp_rnd[j] = pp_q[j] + (RT_W+CFG_W)'(32768);
  end

  // terms in q.4: x amp, x amp, x phase, y amp, y amp, y phase, floor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= pa_rnd[0][31 +: T_W];
      t_q[1] <= pa_rnd[1][31 +: T_W];
      t_q[2] <= pp_rnd[0][16 +: T_W];
      t_q[3] <= pa_rnd[2][31 +: T_W];
      t_q[4] <= pa_rnd[3][31 +: T_W];
      t_q[5] <= pp_rnd[1][16 +: T_W];
      t_q[6] <= T_W'({floor_i, 4'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 7; k++) begin
        tsq_q[k] <= t_q[k] * t_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      usum_q[0] <= SQ_W'(tsq_q[0]) + SQ_W'(tsq_q[1]) + SQ_W'(tsq_q[2]) + SQ_W'(tsq_q[6]);
      usum_q[1] <= SQ_W'(tsq_q[3]) + SQ_W'(tsq_q[4]) + SQ_W'(tsq_q[5]) + SQ_W'(tsq_q[6]);
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_unc
    efu_isqrt u_unc (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .rad_i  (usum_q[j]),
      .root_o (uroot[j])
    );
    assign ur_rnd[j] = {1'b0, uroot[j]} + (RT_W+1)'(8);
    assign ur_sh[j]  = ur_rnd[j][RT_W:4];
  end

  // round to field units and saturate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 2; k++) begin
        if (|ur_sh[k][RT_W-4:FLD_W]) begin
          unc_q[k] <= '1;
        end else begin
          unc_q[k] <= ur_sh[k][FLD_W-1:0];
        end
      end
    end
  end

  assign unc_x_o = unc_q[0];
  assign unc_y_o = unc_q[1];

endmodule

// File: rtl/em_field_uncertainty.sv
`timescale 1ns / 1ps
// path from input transaction to result on the output stream:
// 18 cordic stages, then per lane rotation, two 31-stage square-root chains
// throughput: one item per cycle; the whole pipeline holds only while the
// two-entry output buffer is full
// reset: configuration registers clear to zero, pipeline valids and buffer empty
module em_field_uncertainty import efu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // ex_re, ex_im, ey_re, ey_im, hx_re, hx_im, hy_re, hy_im, rec_angle
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // unc_ex, unc_ey, unc_hx, unc_hy
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  logic [CFG_W-1:0] src_angle_q;
  logic [CFG_W-1:0] amp_frac_q;
  logic [CFG_W-1:0] phase_err_q;
  logic [FLR_W-1:0] floor_e_q;
  logic [FLR_W-1:0] floor_h_q;

  logic                    en;
  logic                    acc;
  logic                    push;
  logic                    pop;
  logic [PIPE_LAT-1:0]     vld_q;
  logic [8*FLD_W-1:0]      fd_q [CORDIC_LAT];
  logic [ANG_W-1:0]        ang;
  logic signed [TRIG_W-1:0] cos_v;
  logic signed [TRIG_W-1:0] sin_v;
  logic [FLD_W-1:0]        unc [4];
  logic [OUT_W-1:0]        buf_q [2];
  logic                    wr_ptr_q;
  logic                    rd_ptr_q;
  logic [1:0]              cnt_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_angle_q <= '0;
      amp_frac_q  <= '0;
      phase_err_q <= '0;
      floor_e_q   <= '0;
      floor_h_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_ANGLE: src_angle_q <= cfg_wdata_i[CFG_W-1:0];
        CFG_AMP_FRAC:  amp_frac_q  <= cfg_wdata_i[CFG_W-1:0];
        CFG_PHASE_ERR: phase_err_q <= cfg_wdata_i[CFG_W-1:0];
        CFG_FLOOR_E:   floor_e_q   <= cfg_wdata_i[FLR_W-1:0];
        CFG_FLOOR_H:   floor_h_q   <= cfg_wdata_i[FLR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances while the output buffer has room
  assign en            = (cnt_q != 2'd2);
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign push          = en && vld_q[PIPE_LAT-1];
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], acc};
    end
  end

  // field delay to meet the trig values
  always_ff @(posedge clk_i) begin
    if (en) begin
      fd_q[0] <= s_axis_tdata[8*FLD_W-1:0];
      for (int k = 1; k < CORDIC_LAT; k++) begin
        fd_q[k] <= fd_q[k-1];
      end
    end
  end

  assign ang = s_axis_tdata[8*FLD_W +: ANG_W] - src_angle_q;

  efu_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang),
    .cos_o (cos_v),
    .sin_o (sin_v)
  );

  // electric lane
  efu_lane u_lane_e (
    .clk_i       (clk_i),
    .en_i        (en),
    .cos_i       (cos_v),
    .sin_i       (sin_v),
    .pair_i      (fd_q[CORDIC_LAT-1][0 +: PAIR_W]),
    .amp_frac_i  (amp_frac_q),
    .phase_err_i (phase_err_q),
    .floor_i     (floor_e_q),
    .unc_x_o     (unc[0]),
    .unc_y_o     (unc[1])
  );

  // magnetic lane
  efu_lane u_lane_h (
    .clk_i       (clk_i),
    .en_i        (en),
    .cos_i       (cos_v),
    .sin_i       (sin_v),
    .pair_i      (fd_q[CORDIC_LAT-1][PAIR_W +: PAIR_W]),
    .amp_frac_i  (amp_frac_q),
    .phase_err_i (phase_err_q),
    .floor_i     (floor_h_q),
    .unc_x_o     (unc[2]),
    .unc_y_o     (unc[3])
  );

  // merge both lanes into the output buffer
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= {unc[3], unc[2], unc[1], unc[0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = buf_q[rd_ptr_q];

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  a_acc_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");
`endif

endmodule
